// ===== rtl/asp_pkg.sv =====
`timescale 1ns / 1ps

package asp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_END        = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BYTE_COUNT  = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // Configuration reset values
    localparam logic [3:0] BYTE_COUNT_RESET  = 4'd8;
    localparam logic       SIGNED_MODE_RESET = 1'b1;

    // Default depth of the result queue
    localparam int RESULT_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    // Up to two results produced by one input item
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } result_pair_t;

    typedef struct packed {
        logic [3:0] byte_count;
        logic       signed_mode;
    } cfg_t;

endpackage

// ===== rtl/asp_step.sv =====
`timescale 1ns / 1ps

module asp_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  asp_pkg::in_item_t    item,
    input  asp_pkg::cfg_t        cfg,
    output asp_pkg::result_pair_t pair
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SIGN   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;

    logic [7:0]  c;
    logic        is_numeral, is_space;
    logic [3:0]  digit;
    logic [3:0]  width_bytes;
    logic [63:0] width_mask;
    logic [63:0] limit;
    logic [67:0] product;
    logic        overflow;
    logic [63:0] value_out;

    logic        idle_emit;
    logic [1:0]  idle_status;
    phase_t      idle_phase;
    logic [63:0] idle_acc;
    logic        idle_neg;

    // Classify the byte
    assign c          = item.data_byte;
    assign is_numeral = c inside {[asp_pkg::CHAR_0:asp_pkg::CHAR_9]};
    assign is_space   = c inside {asp_pkg::CHAR_SPACE, asp_pkg::CHAR_TAB,
                                  asp_pkg::CHAR_CR, asp_pkg::CHAR_LF};
    assign digit      = 4'(c - asp_pkg::CHAR_0);

    // Clamp the width and build the limit for it
    always_comb begin
        if (cfg.byte_count == 4'd0) begin
            width_bytes = 4'd1;
        end else if (cfg.byte_count > 4'd8) begin
            width_bytes = 4'd8;
        end else begin
            width_bytes = cfg.byte_count;
        end
    end

    assign width_mask = ~64'd0 >> (7'd64 - {width_bytes, 3'b000});

    always_comb begin
        if (cfg.signed_mode) begin
            limit = (width_mask >> 1) + 64'(neg_reg);
        end else begin
            limit = width_mask;
        end
    end

    // Times ten plus digit, checked against the limit at full precision
    assign product  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + 68'(digit);
    assign overflow = product > {4'd0, limit};

    assign value_out = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    // Examine the byte as the start of a number
    always_comb begin
        idle_emit   = 1'b0;
        idle_status = asp_pkg::ST_OK;
        idle_phase  = PH_IDLE;
        idle_acc    = 64'd0;
        idle_neg    = 1'b0;
        if (item.end_of_input) begin
            idle_emit   = 1'b1;
            idle_status = asp_pkg::ST_END;
        end else if (is_space) begin
            idle_emit = 1'b0;
        end else if (is_numeral) begin
            idle_acc   = {60'd0, digit};
            idle_phase = PH_DIGITS;
        end else if (c == asp_pkg::CHAR_MINUS && cfg.signed_mode) begin
            idle_neg   = 1'b1;
            idle_phase = PH_SIGN;
        end else begin
            idle_emit   = 1'b1;
            idle_status = asp_pkg::ST_UNEXPECTED;
        end
    end

    // Advance the parser by one item
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        pair        = '0;
        if (fire) begin
            case (phase_reg)
                PH_DIGITS: begin
                    if (!item.end_of_input && is_numeral) begin
                        if (overflow) begin
                            pair.count  = 2'd1;
                            pair.first  = '{value: 64'd0, status: asp_pkg::ST_RANGE,
                                            last: 1'b1};
                            phase_next  = PH_IDLE;
                            acc_next    = 64'd0;
                            neg_next    = 1'b0;
                        end else begin
                            acc_next = product[63:0];
                        end
                    end else begin
                        pair.count  = idle_emit ? 2'd2 : 2'd1;
                        pair.first  = '{value: value_out, status: asp_pkg::ST_OK,
                                        last: !idle_emit};
                        pair.second = '{value: 64'd0, status: idle_status, last: 1'b1};
                        phase_next  = idle_phase;
                        acc_next    = idle_acc;
                        neg_next    = idle_neg;
                    end
                end
                PH_SIGN: begin
                    if (item.end_of_input) begin
                        pair.count = 2'd1;
                        pair.first = '{value: 64'd0, status: asp_pkg::ST_END, last: 1'b1};
                        phase_next = PH_IDLE;
                        acc_next   = 64'd0;
                        neg_next   = 1'b0;
                    end else if (is_numeral) begin
                        acc_next   = {60'd0, digit};
                        phase_next = PH_DIGITS;
                    end else begin
                        pair.count  = idle_emit ? 2'd2 : 2'd1;
                        pair.first  = '{value: 64'd0, status: asp_pkg::ST_UNEXPECTED,
                                        last: !idle_emit};
                        pair.second = '{value: 64'd0, status: idle_status, last: 1'b1};
                        phase_next  = idle_phase;
                        acc_next    = idle_acc;
                        neg_next    = idle_neg;
                    end
                end
                default: begin
                    pair.count = idle_emit ? 2'd1 : 2'd0;
                    pair.first = '{value: 64'd0, status: idle_status, last: 1'b1};
                    phase_next = idle_phase;
                    acc_next   = idle_acc;
                    neg_next   = idle_neg;
                end
            endcase
        end
    end

    // Hold the parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
        end
    end

    // A pair of results always ends with the last flag on the second only
    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && pair.count == 2'd2) |-> (!pair.first.last && pair.second.last))
        else $error("result pair carries a wrong last flag");

    // An end mark always leaves the parser idle
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.end_of_input) |=> (phase_reg == PH_IDLE && acc_reg == 64'd0))
        else $error("parser not idle after end of input");

endmodule

// ===== rtl/asp_queue.sv =====
`timescale 1ns / 1ps

module asp_queue #(
    parameter int DEPTH = asp_pkg::RESULT_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  asp_pkg::result_pair_t push,
    output logic                  has_room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output asp_pkg::out_item_t    m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    asp_pkg::out_item_t mem [DEPTH];

    logic [AW-1:0] wr_reg, wr_next, wr_plus1, wr_plus2;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] res;
        if (ptr == AW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign wr_plus1 = wrap_inc(wr_reg);
    assign wr_plus2 = wrap_inc(wr_plus1);

    // Room for a full pair, judged on the registered count
    assign has_room = (CW'(DEPTH) - count_reg) >= CW'(2);
    assign m_valid  = count_reg != '0;
    assign m_data   = mem[rd_reg];
    assign pop      = m_valid && m_ready;

    // Advance pointers and count
    always_comb begin
        case (push.count)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = wr_plus2;
            default: wr_next = wr_reg;
        endcase
        rd_next    = pop ? wrap_inc(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_plus1] <= push.second;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> ((CW + 1)'(count_reg) + (CW + 1)'(push.count)
                                  <= (CW + 1)'(DEPTH)))
        else $error("result queue written beyond its depth");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("result queue count out of range");

endmodule

// ===== rtl/ascii_decimal_parser_top.sv =====
`timescale 1ns / 1ps

// Decimal integer parser for a byte stream.
// Input channel s_*: one character per transfer in s_data.data_byte, or an
// end-of-stream mark with s_data.end_of_input set. Whitespace is skipped,
// an optional '-' is taken in signed mode, digits build the number.
// Result channel m_*: value, status (ok, end without number, unexpected
// byte, out of range) and last, which flags the final result of one input.
// One input gives zero, one or two results.
// Path: an accepted input is held in the input register, then its results
// are written to the result queue, whose count drives m_valid.
// Throughput: one input per cycle while the result queue has room for a
// pair. The per-byte times-ten-plus-digit update and limit compare are
// combinational; an input giving two results writes both to the queue at once.
// Configuration: cfg_we writes byte_count (index 0) or signed_mode
// (index 1); write only while the parser holds no unfinished work.
// Reset: parser idle, queue empty, byte_count 8, signed_mode 1.
// Stall: a stalled receiver fills the result queue; once it has no room
// for a pair, s_ready drops and no input is lost.
module ascii_decimal_parser_top #(
    parameter int RESULT_DEPTH = asp_pkg::RESULT_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  asp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output asp_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    asp_pkg::cfg_t          cfg_reg;
    logic                   in_vld_reg;
    asp_pkg::in_item_t      in_data_reg;
    logic                   room;
    logic                   proc_fire;
    asp_pkg::result_pair_t  pair;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.byte_count  <= asp_pkg::BYTE_COUNT_RESET;
            cfg_reg.signed_mode <= asp_pkg::SIGNED_MODE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                asp_pkg::CFG_BYTE_COUNT:  cfg_reg.byte_count  <= cfg_data;
                asp_pkg::CFG_SIGNED_MODE: cfg_reg.signed_mode <= cfg_data[0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input register: take a transfer when the register is empty or the held item moves on
    assign proc_fire = in_vld_reg && room;
    assign s_ready   = !in_vld_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    asp_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .pair    (pair)
    );

    asp_queue #(
        .DEPTH (RESULT_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (pair),
        .has_room (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A held item that cannot move on stays put
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !proc_fire) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("held input item lost or changed");

endmodule

// ===== sim/ascii_decimal_parser_top_tb.sv =====
`timescale 1ns / 1ps

module ascii_decimal_parser_top_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 155;
    localparam int NUM_PHASES  = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    // Register settings per random phase: widths past both ends, both sign modes
    localparam int PHASE_BYTES [NUM_PHASES] = '{1, 8, 8, 2, 4, 1, 0, 15, 5, 7, 6, 3};
    localparam int PHASE_SIGNED[NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1};

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SIGN   = 3'b010,
        PH_DIGITS = 3'b100
    } parse_phase_t;

    // Parser model and queue of the results it owes
    class parse_scoreboard;
        logic [3:0]          byte_count;
        logic                signed_mode;
        parse_phase_t        phase;
        logic [63:0]         accumulator;
        logic                negative;
        asp_pkg::out_item_t  pending_results[$];
        int                  errors;
        int                  status_count[4];

        function new();
            byte_count  = asp_pkg::BYTE_COUNT_RESET;
            signed_mode = asp_pkg::SIGNED_MODE_RESET;
            errors      = 0;
            foreach (status_count[i]) status_count[i] = 0;
            go_idle();
        endfunction

        function void go_idle();
            phase       = PH_IDLE;
            accumulator = '0;
            negative    = 1'b0;
        endfunction

        function void write_register(logic index, logic [3:0] data);
            if (index == asp_pkg::CFG_BYTE_COUNT) begin
                byte_count = data;
            end else begin
                signed_mode = data[0];
            end
        endfunction

        // Width 0 behaves as 1, anything past 8 as 8
        function int width_bytes();
            int n;
            n = byte_count;
            if (n < 1) n = 1;
            if (n > 8) n = 8;
            return n;
        endfunction

        function logic [63:0] width_mask();
            int n;
            n = width_bytes();
            if (n == 8) return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function logic [63:0] digit_limit();
            if (signed_mode) return (width_mask() >> 1) + {63'd0, negative};
            return width_mask();
        endfunction

        function logic is_numeral(logic [7:0] c);
            return c >= asp_pkg::CHAR_0 && c <= asp_pkg::CHAR_9;
        endfunction

        function logic is_space(logic [7:0] c);
            return c == asp_pkg::CHAR_SPACE || c == asp_pkg::CHAR_TAB ||
                   c == asp_pkg::CHAR_CR || c == asp_pkg::CHAR_LF;
        endfunction

        function void owe(logic [63:0] value, logic [1:0] status);
            asp_pkg::out_item_t r;
            r.value  = value;
            r.status = status;
            r.last   = 1'b0;
            pending_results = {pending_results, r};
        endfunction

        // Advance the parser by one accepted transfer and queue what it emits
        function void note_byte(asp_pkg::in_item_t item);
            logic [7:0]  c;
            logic        eoi;
            logic [63:0] d;
            logic        again;
            int          before_count;
            c            = item.data_byte;
            eoi          = item.end_of_input;
            again        = 1'b1;
            before_count = pending_results.size();
            case (phase)
                PH_DIGITS: begin
                    if (!eoi && is_numeral(c)) begin
                        d     = {56'd0, c - asp_pkg::CHAR_0};
                        again = 1'b0;
                        if (accumulator > (digit_limit() - d) / 64'd10) begin
                            owe('0, asp_pkg::ST_RANGE);
                            go_idle();
                        end else begin
                            accumulator = accumulator * 64'd10 + d;
                        end
                    end else begin
                        owe(negative ? -accumulator : accumulator, asp_pkg::ST_OK);
                        go_idle();
                    end
                end
                PH_SIGN: begin
                    if (eoi) begin
                        owe('0, asp_pkg::ST_END);
                        go_idle();
                        again = 1'b0;
                    end else if (is_numeral(c)) begin
                        accumulator = {56'd0, c - asp_pkg::CHAR_0};
                        phase       = PH_DIGITS;
                        again       = 1'b0;
                    end else begin
                        owe('0, asp_pkg::ST_UNEXPECTED);
                        go_idle();
                    end
                end
                default: phase = PH_IDLE;
            endcase
            // Examine the byte as the start of a new number
            if (again) begin
                if (eoi) begin
                    owe('0, asp_pkg::ST_END);
                end else if (is_space(c)) begin
                    // skip
                end else if (is_numeral(c)) begin
                    accumulator = {56'd0, c - asp_pkg::CHAR_0};
                    negative    = 1'b0;
                    phase       = PH_DIGITS;
                end else if (c == asp_pkg::CHAR_MINUS && signed_mode) begin
                    accumulator = '0;
                    negative    = 1'b1;
                    phase       = PH_SIGN;
                end else begin
                    owe('0, asp_pkg::ST_UNEXPECTED);
                end
            end
            if (pending_results.size() > before_count) pending_results[$].last = 1'b1;
        endfunction

        function void mismatch(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_result(asp_pkg::out_item_t got);
            asp_pkg::out_item_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %0h/%0d/%0b",
                         $time, got.value, got.status, got.last);
                return;
            end
            want = pending_results.pop_front();
            status_count[want.status]++;
            if (got.value !== want.value) mismatch("value", want.value, got.value);
            if (got.status !== want.status) mismatch("status", want.status, got.status);
            if (got.last !== want.last) mismatch("last", want.last, got.last);
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    asp_pkg::in_item_t   s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    asp_pkg::out_item_t  m_data;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [3:0]          cfg_data  = '0;

    parse_scoreboard board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int sent_items    = 0;
    int cycles        = 0;

    ascii_decimal_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when asked for
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // Offer one item after a random gap; returns at the accepting edge
    task automatic send_item(input logic [7:0] b, input logic eoi);
        asp_pkg::in_item_t item;
        item.data_byte    = b;
        item.end_of_input = eoi;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(item);
        sent_items++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
    endtask

    task automatic wait_for_results();
        while (board.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Drop valid, let every owed result arrive, then settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic configure(input logic [3:0] bytes, input logic sign_mode);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= asp_pkg::CFG_BYTE_COUNT;
        cfg_data  <= bytes;
        board.write_register(asp_pkg::CFG_BYTE_COUNT, bytes);
        @(negedge aclk);
        cfg_index <= asp_pkg::CFG_SIGNED_MODE;
        cfg_data  <= {3'd0, sign_mode};
        board.write_register(asp_pkg::CFG_SIGNED_MODE, {3'd0, sign_mode});
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return asp_pkg::CHAR_SPACE;
            1:       return asp_pkg::CHAR_TAB;
            2:       return asp_pkg::CHAR_CR;
            default: return asp_pkg::CHAR_LF;
        endcase
    endfunction

    // Send one number, biased towards the limit of the current width
    task automatic send_number();
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] rem;
        logic [7:0]  digits[$];
        int          n;
        n    = board.width_bytes();
        mask = board.width_mask();
        case ($urandom_range(7))
            0, 1:    mag = 64'($urandom_range(999));
            2, 3:    mag = {$urandom, $urandom} & mask;
            4:       mag = (board.signed_mode ? mask >> 1 : mask) - 64'($urandom_range(2));
            5:       mag = (board.signed_mode ? mask >> 1 : mask) + 64'($urandom_range(1, 2));
            6:       mag = ({$urandom, $urandom} & mask) >> $urandom_range(8 * n - 1);
            default: mag = {$urandom, $urandom};
        endcase
        do begin
            rem = mag % 64'd10;
            digits.push_front(asp_pkg::CHAR_0 + rem[7:0]);
            mag = mag / 64'd10;
        end while (mag != 0);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) digits.push_front(asp_pkg::CHAR_0);
        end
        if ($urandom_range(7) == 0) begin
            digits = {digits, asp_pkg::CHAR_0 + 8'($urandom_range(9))};
        end
        if (board.signed_mode ? $urandom_range(9) < 4 : $urandom_range(19) == 0) begin
            send_item(asp_pkg::CHAR_MINUS, 1'b0);
        end
        foreach (digits[i]) send_item(digits[i], 1'b0);
        // Terminate: mostly whitespace, sometimes junk, an end mark or nothing
        case ($urandom_range(19))
            16, 17:  send_item(8'($urandom_range(255)), 1'b0);
            18:      send_item(8'($urandom_range(255)), 1'b1);
            19:      ;
            default: send_item(pick_blank(), 1'b0);
        endcase
    endtask

    initial begin
        int  goal;
        logic paused;
        board  = new();
        paused = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: one-byte signed limits, stray bytes, sign corner cases
        send_idle_pct = 7;
        recv_idle_pct = 84;
        configure(4'd1, 1'b1);
        send_text("127 ");
        send_text("-128");
        send_item(8'h00, 1'b1);
        send_text("128");
        send_text("-x");
        send_text("-");
        send_item(8'hff, 1'b1);
        send_text("-0\t");
        send_item(8'hff, 1'b0);
        send_text("\r\n7");
        send_item(8'hff, 1'b1);
        drain();

        // Random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 4) ? 7 : (p < 8) ? 84 : 0;
            recv_idle_pct = (p < 4) ? 84 : (p < 8) ? 7 : 0;
            configure(4'(PHASE_BYTES[p]), 1'(PHASE_SIGNED[p]));
            if (p == 9) hold_requests++;
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal) begin
                // Hold the sender once mid-stream until the results catch up
                if (p == 2 && !paused && sent_items >= goal - PHASE_ITEMS / 2) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    wait_for_results();
                    paused = 1'b1;
                end
                case ($urandom_range(19))
                    15, 16: send_item(8'($urandom_range(255)), 1'b0);
                    17: begin
                        send_item(asp_pkg::CHAR_MINUS, 1'b0);
                        send_item(8'($urandom_range(255)), 1'b0);
                    end
                    18:      send_item(8'($urandom_range(255)), 1'b1);
                    19:      repeat ($urandom_range(1, 3)) send_item(pick_blank(), 1'b0);
                    default: send_number();
                endcase
            end
            send_item(8'($urandom_range(255)), 1'b1);
            drain();
        end

        $display("run covered %0d input transfers over %0d register settings, widths 0 to 15",
                 sent_items, NUM_PHASES + 1);
        $display("results checked: %0d values, %0d ends, %0d unexpected bytes, %0d out of range",
                 board.status_count[asp_pkg::ST_OK], board.status_count[asp_pkg::ST_END],
                 board.status_count[asp_pkg::ST_UNEXPECTED],
                 board.status_count[asp_pkg::ST_RANGE]);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
